@@ design/sfa_pkg.sv @@
// sprite frame animation sequencer: shared types and constants
// no dependencies; imported by sfa_table, sfa_core and the top level
package sfa_pkg;

  localparam int FRAME_W = 4;
  localparam int SUB_W   = 8;
  localparam int VALUE_W = 16;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;
  localparam int TL_W    = 24;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_FRAME  = 2'd1,
    OP_LOAD_ENTRY = 2'd2,
    OP_RESTART    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_FWD  = 2'd0,
    DIR_BWD  = 2'd1,
    DIR_HALT = 2'd2
  } dir_t;

  localparam logic [1:0] MODE_REPEAT   = 2'd0;
  localparam logic [1:0] MODE_PINGPONG = 2'd1;
  localparam logic [1:0] MODE_HALT     = 2'd2;

  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_REPEAT_FROM = 2'd1;
  localparam logic [1:0] REG_FRAME_COUNT = 2'd2;

  localparam logic signed [TL_W-1:0] TL_MIN = {1'b1, {(TL_W-1){1'b0}}};
  localparam logic signed [TL_W-1:0] TL_MAX = {1'b0, {(TL_W-1){1'b1}}};

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [SUB_W-1:0]   subtexture;
    logic [1:0]         direction;
    logic               error;
  } sfa_result_t;

endpackage

@@ design/sprite_frame_animation_sequencer_top.sv @@
// sprite frame animation sequencer, top level
// input register, config registers and result register around sfa_core; uses sfa_pkg
//
// usage:
//   input channel (in_valid/in_ready) carries one item: op, value, entry_index,
//   entry_subtexture, entry_duration. ops are tick, set_frame, load_entry, restart.
//   output channel (out_valid/out_ready) returns exactly one result per item:
//   frame, subtexture, direction, error.
//   config writes (cfg_write, cfg_index, cfg_data) set mode, repeat_from and
//   frame_count; they take effect at once and are meant for an idle block.
// timing:
//   an accepted item is held in the input register, is processed by a subtract,
//   saturate, frame step and table read, and lands in the result register;
//   out_valid rises when the item moves from the input register to the result register.
//   throughput is one item per clock while out_ready is high; the frame/tick state
//   registers update together with the result register.
// reset (rst, synchronous): frame 0, forwards, zero ticks left, mode repeat,
//   repeat_from 0, frame_count 1, both channels empty. the frame table holds
//   no reset value and must be loaded before it is shown.
// stall: when out_ready is low the result is held and one further item is
//   held in the input register; in_ready drops only when both are full.
module sprite_frame_animation_sequencer_top #(
  parameter int MAX_FRAMES    = 16,
  parameter int DURATION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sfa_pkg::op_t                  op,
  input  logic [sfa_pkg::VALUE_W-1:0]   value,
  input  logic [sfa_pkg::INDEX_W-1:0]   entry_index,
  input  logic [sfa_pkg::SUB_W-1:0]     entry_subtexture,
  input  logic [sfa_pkg::VALUE_W-1:0]   entry_duration,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfa_pkg::FRAME_W-1:0]   frame,
  output logic [sfa_pkg::SUB_W-1:0]     subtexture,
  output logic [1:0]                    direction,
  output logic                          error,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [sfa_pkg::COUNT_W-1:0]   cfg_data
);
  import sfa_pkg::*;

  logic                 item_valid;
  op_t                  item_op;
  logic [VALUE_W-1:0]   item_value;
  logic [INDEX_W-1:0]   item_index;
  logic [SUB_W-1:0]     item_sub;
  logic [VALUE_W-1:0]   item_dur;

  logic [1:0]           mode;
  logic [FRAME_W-1:0]   repeat_from;
  logic [COUNT_W-1:0]   frame_count;

  sfa_result_t          res;
  sfa_result_t          result;
  logic                 fire;

  assign fire     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_op    <= op;
      item_value <= value;
      item_index <= entry_index;
      item_sub   <= entry_subtexture;
      item_dur   <= entry_duration;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_REPEAT;
      repeat_from <= '0;
      frame_count <= COUNT_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:        mode        <= cfg_data[1:0];
        REG_REPEAT_FROM: repeat_from <= cfg_data[FRAME_W-1:0];
        REG_FRAME_COUNT: frame_count <= cfg_data;
        default: begin
          mode <= mode;
        end
      endcase
    end
  end

  sfa_core #(
    .MAX_FRAMES   (MAX_FRAMES),
    .DURATION_BITS(DURATION_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item_op    (item_op),
    .item_value (item_value),
    .item_index (item_index),
    .item_sub   (item_sub),
    .item_dur   (item_dur),
    .mode       (mode),
    .repeat_from(repeat_from),
    .frame_count(frame_count),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res;
    end
  end

  assign frame      = result.frame;
  assign subtexture = result.subtexture;
  assign direction  = result.direction;
  assign error      = result.error;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed item did not produce a result");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !fire |=> item_valid && $stable(item_op) && $stable(item_value))
    else $error("stalled item lost or changed in input register");

  a_tick_no_error: assert property (@(posedge clk) disable iff (rst)
    fire && (item_op == OP_TICK) |=> !result.error)
    else $error("tick item flagged an error");

  a_restart_home: assert property (@(posedge clk) disable iff (rst)
    fire && (item_op == OP_RESTART) |=> (result.frame == '0) && (result.direction == DIR_FWD))
    else $error("restart did not return to frame zero forwards");

endmodule

@@ design/sfa_table.sv @@
// frame table: sub-texture index and display duration per frame slot
// one write port, one combinational read port; uses sfa_pkg
module sfa_table #(
  parameter int MAX_FRAMES    = 16,
  parameter int DURATION_BITS = 16,
  parameter int IDX_W         = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [IDX_W-1:0]         waddr,
  input  logic [sfa_pkg::SUB_W-1:0] wsub,
  input  logic [DURATION_BITS-1:0] wdur,
  input  logic [IDX_W-1:0]         raddr,
  output logic [sfa_pkg::SUB_W-1:0] rsub,
  output logic [DURATION_BITS-1:0] rdur
);
  import sfa_pkg::*;

  logic [SUB_W-1:0]         sub_mem [MAX_FRAMES];
  logic [DURATION_BITS-1:0] dur_mem [MAX_FRAMES];

  always_ff @(posedge clk) begin
    if (we) begin
      sub_mem[waddr] <= wsub;
      dur_mem[waddr] <= wdur;
    end
  end

  assign rsub = sub_mem[raddr];
  assign rdur = dur_mem[raddr];

endmodule

@@ design/sfa_core.sv @@
// animation state and combinational next-state update for one item
// holds frame, direction and remaining tick count; uses sfa_pkg and sfa_table
module sfa_core #(
  parameter int MAX_FRAMES    = 16,
  parameter int DURATION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  sfa_pkg::op_t                  item_op,
  input  logic [sfa_pkg::VALUE_W-1:0]   item_value,
  input  logic [sfa_pkg::INDEX_W-1:0]   item_index,
  input  logic [sfa_pkg::SUB_W-1:0]     item_sub,
  input  logic [sfa_pkg::VALUE_W-1:0]   item_dur,
  input  logic [1:0]                    mode,
  input  logic [sfa_pkg::FRAME_W-1:0]   repeat_from,
  input  logic [sfa_pkg::COUNT_W-1:0]   frame_count,
  output sfa_pkg::sfa_result_t          res
);
  import sfa_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int DB    = DURATION_BITS;
  localparam int SW    = ((DB > TL_W) ? DB : TL_W) + 2;
  localparam logic [8:0] MF = 9'(MAX_FRAMES);

  logic [FRAME_W-1:0]      current_frame, frame_next;
  dir_t                    play_direction, dir_next;
  logic signed [TL_W-1:0]  ticks_left, ticks_left_next;

  logic [COUNT_W-1:0]      count, count_m1, count_m2;
  logic                    at_end;
  logic [FRAME_W-1:0]      adv_frame;
  dir_t                    adv_dir;

  logic signed [TL_W+1:0]  diff;
  logic signed [TL_W-1:0]  tl_dec;
  logic                    le0;
  logic signed [TL_W-1:0]  base;
  logic signed [SW-1:0]    sum;
  logic signed [TL_W-1:0]  tl_add;

  logic [DB+VALUE_W-1:0]   dur_ext;
  logic [DB-1:0]           dur_m;
  logic [IDX_W+FRAME_W-1:0] ra_ext;
  logic [IDX_W+INDEX_W-1:0] wa_ext;
  logic [IDX_W-1:0]        raddr, waddr;
  logic [SUB_W-1:0]        rsub;
  logic [DB-1:0]           rdur;
  logic                    we;
  logic                    err;

  // frames in use, clamped to 1..MAX_FRAMES
  always_comb begin
    if (frame_count == '0) begin
      count = COUNT_W'(1);
    end else if ({4'b0, frame_count} > MF) begin
      count = MF[COUNT_W-1:0];
    end else begin
      count = frame_count;
    end
  end

  assign count_m1 = count - COUNT_W'(1);
  assign count_m2 = count - COUNT_W'(2);
  assign at_end   = ({1'b0, current_frame} + COUNT_W'(1)) >= count;

  // frame step by mode
  always_comb begin
    adv_frame = current_frame;
    adv_dir   = play_direction;
    case (mode)
      MODE_HALT: begin
        if (at_end) begin
          adv_frame = count_m1[FRAME_W-1:0];
          adv_dir   = DIR_HALT;
        end else begin
          adv_frame = current_frame + FRAME_W'(1);
        end
      end
      MODE_PINGPONG: begin
        if (play_direction == DIR_FWD) begin
          if (at_end) begin
            if (count >= COUNT_W'(2)) begin
              adv_frame = count_m2[FRAME_W-1:0];
              adv_dir   = DIR_BWD;
            end else begin
              adv_frame = '0;
            end
          end else begin
            adv_frame = current_frame + FRAME_W'(1);
          end
        end else begin
          if (current_frame == '0) begin
            if (count >= COUNT_W'(2)) begin
              adv_frame = FRAME_W'(1);
              adv_dir   = DIR_FWD;
            end
          end else begin
            adv_frame = current_frame - FRAME_W'(1);
          end
        end
      end
      default: begin
        // repeat, and the unused mode code behaves the same
        if (at_end) begin
          adv_frame = ({1'b0, repeat_from} < count) ? repeat_from : '0;
        end else begin
          adv_frame = current_frame + FRAME_W'(1);
        end
      end
    endcase
  end

  // saturating subtract of elapsed ticks
  always_comb begin
    diff = $signed({{2{ticks_left[TL_W-1]}}, ticks_left})
         - $signed({{(TL_W+2-VALUE_W){1'b0}}, item_value});
    if ((&diff[TL_W+1:TL_W-1]) || !(|diff[TL_W+1:TL_W-1])) begin
      tl_dec = diff[TL_W-1:0];
    end else begin
      tl_dec = diff[TL_W+1] ? TL_MIN : TL_MAX;
    end
  end

  assign le0 = tl_dec[TL_W-1] || (tl_dec == '0);

  // saturating add of the new frame's duration
  always_comb begin
    base = (item_op == OP_TICK) ? tl_dec : '0;
    sum  = $signed({{(SW-TL_W){base[TL_W-1]}}, base}) + $signed({{(SW-DB){1'b0}}, rdur});
    if ((&sum[SW-1:TL_W-1]) || !(|sum[SW-1:TL_W-1])) begin
      tl_add = sum[TL_W-1:0];
    end else begin
      tl_add = sum[SW-1] ? TL_MIN : TL_MAX;
    end
  end

  assign dur_ext = {{DB{1'b0}}, item_dur};
  assign dur_m   = dur_ext[DB-1:0];

  always_comb begin
    frame_next      = current_frame;
    dir_next        = play_direction;
    ticks_left_next = ticks_left;
    err             = 1'b0;
    we              = 1'b0;
    case (item_op)
      OP_TICK: begin
        if (play_direction != DIR_HALT) begin
          ticks_left_next = tl_dec;
          if (le0) begin
            frame_next      = adv_frame;
            dir_next        = adv_dir;
            ticks_left_next = tl_add;
          end
        end
      end
      OP_SET_FRAME: begin
        if (item_value >= {{(VALUE_W-COUNT_W){1'b0}}, count}) begin
          err = 1'b1;
        end else begin
          frame_next      = item_value[FRAME_W-1:0];
          ticks_left_next = tl_add;
        end
      end
      OP_LOAD_ENTRY: begin
        if ((dur_m == '0) || ({5'b0, item_index} >= MF)) begin
          err = 1'b1;
        end else begin
          we = 1'b1;
        end
      end
      OP_RESTART: begin
        frame_next      = '0;
        dir_next        = DIR_FWD;
        ticks_left_next = tl_add;
      end
      default: begin
        err = 1'b0;
      end
    endcase
  end

  assign ra_ext = {{IDX_W{1'b0}}, frame_next};
  assign raddr  = ra_ext[IDX_W-1:0];
  assign wa_ext = {{IDX_W{1'b0}}, item_index};
  assign waddr  = wa_ext[IDX_W-1:0];

  sfa_table #(
    .MAX_FRAMES   (MAX_FRAMES),
    .DURATION_BITS(DURATION_BITS)
  ) u_table (
    .clk  (clk),
    .we   (fire && we),
    .waddr(waddr),
    .wsub (item_sub),
    .wdur (dur_m),
    .raddr(raddr),
    .rsub (rsub),
    .rdur (rdur)
  );

  // a load into the shown frame is visible in the same result
  always_comb begin
    res.frame      = frame_next;
    res.subtexture = (we && (waddr == raddr)) ? item_sub : rsub;
    res.direction  = dir_next;
    res.error      = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_frame  <= '0;
      play_direction <= DIR_FWD;
      ticks_left     <= '0;
    end else if (fire) begin
      current_frame  <= frame_next;
      play_direction <= dir_next;
      ticks_left     <= ticks_left_next;
    end
  end

endmodule
